// File: sv/assembler_token_classifier_assert.svh
// Assertion macros shared by the assembler token classifier RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSEMBLER_TOKEN_CLASSIFIER_ASSERT_SVH
`define ASSEMBLER_TOKEN_CLASSIFIER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define ATC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assembler token classifier: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define ATC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assembler token classifier: next-cycle check failed");

`endif

// File: sv/atc_pkg.sv
// Package for the assembler token classifier: character codes, class codes,
// the state summary struct and the mnemonic name table. Depends on nothing.
package atc_pkg;

    localparam int MAX_TOKEN_LEN_DEF  = 64;
    localparam int MNEMONIC_COUNT_DEF = 31;

    // Bracket positions are 8 bits wide; all ones means no bracket seen.
    localparam int             POS_W     = 8;
    localparam logic [POS_W-1:0] NOT_FOUND = 8'hFF;
    // Longest name slot, terminator included.
    localparam int             NAME_SLOT = 8;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_B   = 8'h62;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_LOW_O   = 8'h6F;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef enum logic [3:0] {
        CLS_LABEL        = 4'd0,
        CLS_COMMENT      = 4'd1,
        CLS_REGISTER     = 4'd2,
        CLS_DECIMAL      = 4'd3,
        CLS_HEX          = 4'd4,
        CLS_BINARY       = 4'd5,
        CLS_OCTAL        = 4'd6,
        CLS_STRING       = 4'd7,
        CLS_MNEMONIC     = 4'd8,
        CLS_OFFSET       = 4'd9,
        CLS_UNRECOGNIZED = 4'd10
    } t_token_class;

    // Flag bits of the character-kind flags.
    localparam int FLG_ALL_DIGIT = 0;
    localparam int FLG_ALL_LOWER = 1;
    localparam int FLG_HEX_TAIL  = 2;

    // Flag bits of the offset check flags.
    localparam int OFF_DOLLAR    = 0;
    localparam int OFF_LETTER    = 1;
    localparam int OFF_BAD_CHAR  = 2;
    localparam int OFF_CLEAN_END = 3;

    // Token state after the current character, as seen by the classifier.
    typedef struct packed {
        logic [POS_W-1:0] count;
        logic [15:0]      first_two;
        logic [2:0]       kind_flags;
        logic [POS_W-1:0] open_pos;
        logic [POS_W-1:0] close_pos;
        logic [3:0]       off_flags;
        logic             overlong;
    } t_tok_info;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    typedef struct packed {
        t_token_class cls;
        logic [4:0]   idx;
        logic         accepted;
    } t_result;

    // Name of a table entry, first character in the top byte, zero padded.
    function automatic logic [63:0] mnem_name(input logic [5:0] idx);
        logic [63:0] r;
        unique case (idx)
            6'd0:    r = {"nop",   40'h0};
            6'd1:    r = {"jmp",   40'h0};
            6'd2:    r = {"llo",   40'h0};
            6'd3:    r = {"lhi",   40'h0};
            6'd4:    r = {"lw",    48'h0};
            6'd5:    r = {"sw",    48'h0};
            6'd6:    r = {"beq",   40'h0};
            6'd7:    r = {"bne",   40'h0};
            6'd8:    r = {"and",   40'h0};
            6'd9:    r = {"or",    48'h0};
            6'd10:   r = {"xor",   40'h0};
            6'd11:   r = {"slt",   40'h0};
            6'd12:   r = {"uadd",  32'h0};
            6'd13:   r = {"sadd",  32'h0};
            6'd14:   r = {"ssub",  32'h0};
            6'd15:   r = {"usub",  32'h0};
            6'd16:   r = {"blt",   40'h0};
            6'd17:   r = {"bgt",   40'h0};
            6'd18:   r = {"bge",   40'h0};
            6'd19:   r = {"ble",   40'h0};
            6'd20:   r = {"inc",   40'h0};
            6'd21:   r = {"dec",   40'h0};
            6'd22:   r = {"mul",   40'h0};
            6'd23:   r = {"div",   40'h0};
            6'd24:   r = {"sll",   40'h0};
            6'd25:   r = {"srl",   40'h0};
            6'd26:   r = {"push",  32'h0};
            6'd27:   r = {"pop",   40'h0};
            6'd28:   r = {"not",   40'h0};
            6'd29:   r = {"rem",   40'h0};
            6'd30:   r = {"clear", 24'h0};
            default: r = 64'h0;
        endcase
        return r;
    endfunction

    // Character at a position of a table entry (zero past the name's end).
    function automatic logic [7:0] mnem_char(input logic [5:0] idx, input logic [2:0] pos);
        logic [63:0] w;
        logic [5:0]  sh;
        sh = {3'(3'd7 - pos), 3'b000};
        w  = mnem_name(idx) >> sh;
        return w[7:0];
    endfunction

endpackage

// File: sv/assembler_token_classifier.sv
// Top level of the assembler token classifier: input register, token state,
// class decision and result register. Depends on atc_pkg and the atc_* modules.
//
// The block takes the characters of one assembler token, one character per
// slave transaction, with tlast set on the final character. Nothing comes out
// for the other characters; on the final one the block delivers one master
// transaction with the token's class (label, comment, register, decimal, hex,
// binary, octal, string, mnemonic, offset or unrecognized), the mnemonic table
// index when the class is mnemonic, and an accepted flag that is low for
// strings and unrecognized tokens. Binary and octal literals take the digits
// 0-9 and a-f just like hex. A token longer than MAX_TOKEN_LEN characters is
// unrecognized. The block sustains one character per clock cycle while no
// final character waits for the result register. A final character passes
// through the input register and then the result register before its result
// transaction is offered. The token state updates from the registered
// character in a single step: flags, bracket positions and the per-entry
// mnemonic match vector all change together. The result register parts the
// two sides, so the characters of the next token keep flowing while a result
// waits to be taken; only the next final character waits for it. The block
// starts working directly after reset with no initialization sweep.
`include "assembler_token_classifier_assert.svh"

module assembler_token_classifier #(
    parameter int MAX_TOKEN_LEN  = atc_pkg::MAX_TOKEN_LEN_DEF,
    parameter int MNEMONIC_COUNT = atc_pkg::MNEMONIC_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata fields from the lowest bit: ch [7:0].
    input  logic [7:0]  i_s_tdata,
    // tlast marks the final character of the token.
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata fields from the lowest bit: token_class [3:0], mnemonic_index [8:4],
    // accepted [9], zero fill [15:10].
    output logic [15:0] o_m_tdata
);

    atc_pkg::t_in_item         in_item, stage_item;
    logic                      stage_valid;
    logic                      step;
    atc_pkg::t_tok_info        info;
    logic [MNEMONIC_COUNT-1:0] match;
    atc_pkg::t_result          result;

    logic                      r_out_valid;
    atc_pkg::t_result          r_out;

    assign in_item.ch   = i_s_tdata;
    assign in_item.last = i_s_tlast;

    // A character that ends no token moves on at once; the final character
    // waits until the result register has room for its result.
    assign step = stage_valid && (!stage_item.last || !r_out_valid || i_m_tready);

    atc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    atc_tracker #(
        .MAX_TOKEN_LEN  (MAX_TOKEN_LEN),
        .MNEMONIC_COUNT (MNEMONIC_COUNT)
    ) u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (stage_item),
        .o_info  (info),
        .o_match (match)
    );

    atc_classify #(
        .MNEMONIC_COUNT (MNEMONIC_COUNT)
    ) u_classify (
        .i_info   (info),
        .i_match  (match),
        .i_ch     (stage_item.ch),
        .o_result (result)
    );

    // Result register: loaded on the last character, drained by the master side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && stage_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && stage_item.last) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out.accepted, r_out.idx, r_out.cls};

    // A last character that moves on always leaves a result behind.
    `ATC_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, step && stage_item.last, r_out_valid)
    // The slave side only stalls while the input register holds a character.
    `ATC_ASSERT_SAME(a_stall_needs_item, i_clk, i_rst_n, !o_s_tready, stage_valid)
    // A table index only comes with the mnemonic class.
    `ATC_ASSERT_SAME(a_index_only_mnemonic, i_clk, i_rst_n,
                     r_out_valid && (r_out.idx != 5'd0), r_out.cls == atc_pkg::CLS_MNEMONIC)
    // Rejected results are exactly the string and unrecognized classes.
    `ATC_ASSERT_SAME(a_accept_matches_class, i_clk, i_rst_n, r_out_valid,
                     r_out.accepted == ((r_out.cls != atc_pkg::CLS_STRING)
                                     && (r_out.cls != atc_pkg::CLS_UNRECOGNIZED)))

endmodule

// File: sv/atc_in_stage.sv
// Input register of the assembler token classifier: holds one character
// transaction until the token stage takes it. Depends on atc_pkg.
module atc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  atc_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output atc_pkg::t_in_item o_item
);

    logic              r_valid;
    atc_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: sv/atc_tracker.sv
// Running token state of the assembler token classifier: counts, flags,
// bracket positions and the mnemonic match vector. Depends on atc_pkg.
module atc_tracker #(
    parameter int MAX_TOKEN_LEN  = atc_pkg::MAX_TOKEN_LEN_DEF,
    parameter int MNEMONIC_COUNT = atc_pkg::MNEMONIC_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  atc_pkg::t_in_item         i_item,
    output atc_pkg::t_tok_info        o_info,
    output logic [MNEMONIC_COUNT-1:0] o_match
);

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [MNEMONIC_COUNT-1:0] MATCH_ALL = {MNEMONIC_COUNT{1'b1}};

    logic [CNT_W-1:0]          r_count,     n_count;
    logic [15:0]               r_first_two, n_first_two;
    logic [2:0]                r_kind,      n_kind;
    logic [atc_pkg::POS_W-1:0] r_open,      n_open;
    logic [atc_pkg::POS_W-1:0] r_close,     n_close;
    logic [3:0]                r_off,       n_off;
    logic [MNEMONIC_COUNT-1:0] r_match,     n_match;
    logic                      r_overlong,  n_overlong;

    logic [7:0] ch;
    logic       dig, low, hexd;
    logic [8:0] p9;

    assign ch   = i_item.ch;
    assign dig  = (ch >= atc_pkg::CH_ZERO) && (ch <= atc_pkg::CH_NINE);
    assign low  = (ch >= atc_pkg::CH_LOW_A) && (ch <= atc_pkg::CH_LOW_Z);
    assign hexd = dig || ((ch >= atc_pkg::CH_LOW_A) && (ch <= atc_pkg::CH_LOW_F));
    assign p9   = 9'(r_count);

    always_comb begin
        n_count     = r_count;
        n_first_two = r_first_two;
        n_kind      = r_kind;
        n_open      = r_open;
        n_close     = r_close;
        n_off       = r_off;
        n_match     = r_match;
        n_overlong  = r_overlong;
        if (r_overlong || (r_count >= CNT_W'(MAX_TOKEN_LEN))) begin
            n_overlong = 1'b1;
        end else begin
            if (!dig) n_kind[atc_pkg::FLG_ALL_DIGIT] = 1'b0;
            if (!low) n_kind[atc_pkg::FLG_ALL_LOWER] = 1'b0;
            if ((r_count >= CNT_W'(2)) && !hexd) n_kind[atc_pkg::FLG_HEX_TAIL] = 1'b0;
            if (r_count == CNT_W'(0)) n_first_two[7:0]  = r_first_two[7:0] | ch;
            if (r_count == CNT_W'(1)) n_first_two[15:8] = r_first_two[15:8] | ch;

            if (r_open == atc_pkg::NOT_FOUND) begin
                if ((ch == atc_pkg::CH_LPAREN) || (ch == atc_pkg::CH_LBRACK)) begin
                    n_open = atc_pkg::POS_W'(r_count);
                end
            end else begin
                if ((p9 == (9'(r_open) + 9'd1)) && (ch == atc_pkg::CH_DOLLAR)) begin
                    n_off[atc_pkg::OFF_DOLLAR] = 1'b1;
                end
                if ((p9 == (9'(r_open) + 9'd2)) && low) begin
                    n_off[atc_pkg::OFF_LETTER] = 1'b1;
                end
            end

            // A closing bracket marks a clean end only if no stray character came first.
            if ((ch == atc_pkg::CH_RPAREN) || (ch == atc_pkg::CH_RBRACK)) begin
                n_close = atc_pkg::POS_W'(r_count);
                n_off[atc_pkg::OFF_CLEAN_END] = !r_off[atc_pkg::OFF_BAD_CHAR];
            end
            if ((n_open != atc_pkg::NOT_FOUND) && (p9 >= (9'(n_open) + 9'd3))
                    && !(low || dig)) begin
                n_off[atc_pkg::OFF_BAD_CHAR] = 1'b1;
            end

            for (int i = 0; i < MNEMONIC_COUNT; i++) begin
                if ((r_count >= CNT_W'(atc_pkg::NAME_SLOT - 1))
                        || (atc_pkg::mnem_char(6'(i), r_count[2:0]) != ch)) begin
                    n_match[i] = 1'b0;
                end
            end
            n_count = CNT_W'(r_count + CNT_W'(1));
        end
    end

    always_comb begin
        o_info.count      = atc_pkg::POS_W'(n_count);
        o_info.first_two  = n_first_two;
        o_info.kind_flags = n_kind;
        o_info.open_pos   = n_open;
        o_info.close_pos  = n_close;
        o_info.off_flags  = n_off;
        o_info.overlong   = n_overlong;
        o_match           = n_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last)) begin
            r_count     <= '0;
            r_first_two <= '0;
            r_kind      <= 3'b111;
            r_open      <= atc_pkg::NOT_FOUND;
            r_close     <= atc_pkg::NOT_FOUND;
            r_off       <= '0;
            r_match     <= MATCH_ALL;
            r_overlong  <= 1'b0;
        end else if (i_step) begin
            r_count     <= n_count;
            r_first_two <= n_first_two;
            r_kind      <= n_kind;
            r_open      <= n_open;
            r_close     <= n_close;
            r_off       <= n_off;
            r_match     <= n_match;
            r_overlong  <= n_overlong;
        end
    end

endmodule

// File: sv/atc_classify.sv
// Final class decision of the assembler token classifier, taken on the
// token's last character. Depends on atc_pkg.
module atc_classify #(
    parameter int MNEMONIC_COUNT = atc_pkg::MNEMONIC_COUNT_DEF
) (
    input  atc_pkg::t_tok_info        i_info,
    input  logic [MNEMONIC_COUNT-1:0] i_match,
    input  logic [7:0]                i_ch,
    output atc_pkg::t_result          o_result
);

    logic [7:0] c0, c1;
    logic       n_ge2, n_ge3, tail_ok, found;
    logic [4:0] hit_idx;

    assign c0      = i_info.first_two[7:0];
    assign c1      = i_info.first_two[15:8];
    assign n_ge2   = i_info.count >= atc_pkg::POS_W'(2);
    assign n_ge3   = i_info.count >= atc_pkg::POS_W'(3);
    assign tail_ok = i_info.kind_flags[atc_pkg::FLG_HEX_TAIL];

    // Lowest surviving entry whose name ends exactly at the token length.
    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        if (n_ge2 && (i_info.count < atc_pkg::POS_W'(atc_pkg::NAME_SLOT))) begin
            for (int i = MNEMONIC_COUNT - 1; i >= 0; i--) begin
                if (i_match[i]
                        && (atc_pkg::mnem_char(6'(i), i_info.count[2:0]) == atc_pkg::CH_NUL)) begin
                    found   = 1'b1;
                    hit_idx = 5'(i);
                end
            end
        end
    end

    always_comb begin
        o_result.idx = '0;
        priority if (i_info.overlong) begin
            o_result.cls = atc_pkg::CLS_UNRECOGNIZED;
        end else if (n_ge2 && (i_ch == atc_pkg::CH_COLON)) begin
            o_result.cls = atc_pkg::CLS_LABEL;
        end else if (c0 == atc_pkg::CH_HASH) begin
            o_result.cls = atc_pkg::CLS_COMMENT;
        end else if (c0 == atc_pkg::CH_DOLLAR) begin
            o_result.cls = atc_pkg::CLS_REGISTER;
        end else if (i_info.kind_flags[atc_pkg::FLG_ALL_DIGIT]) begin
            o_result.cls = atc_pkg::CLS_DECIMAL;
        end else if (n_ge3 && (c0 == atc_pkg::CH_ZERO) && (c1 == atc_pkg::CH_LOW_X)
                     && tail_ok) begin
            o_result.cls = atc_pkg::CLS_HEX;
        end else if (n_ge3 && (c0 == atc_pkg::CH_ZERO) && (c1 == atc_pkg::CH_LOW_B)
                     && tail_ok) begin
            o_result.cls = atc_pkg::CLS_BINARY;
        end else if (n_ge3 && (c0 == atc_pkg::CH_ZERO) && (c1 == atc_pkg::CH_LOW_O)
                     && tail_ok) begin
            o_result.cls = atc_pkg::CLS_OCTAL;
        end else if (n_ge2 && (c0 == atc_pkg::CH_QUOTE) && (i_ch == atc_pkg::CH_QUOTE)) begin
            o_result.cls = atc_pkg::CLS_STRING;
        end else if (i_info.kind_flags[atc_pkg::FLG_ALL_LOWER]) begin
            o_result.cls = found ? atc_pkg::CLS_MNEMONIC : atc_pkg::CLS_UNRECOGNIZED;
            o_result.idx = found ? hit_idx : 5'd0;
        end else if ((i_info.count >= atc_pkg::POS_W'(5))
                     && (i_info.open_pos != atc_pkg::NOT_FOUND)
                     && (i_info.close_pos != atc_pkg::NOT_FOUND)
                     && (i_info.open_pos < i_info.close_pos)
                     && ((9'(i_info.open_pos) + 9'd2) < 9'(i_info.count))
                     && i_info.off_flags[atc_pkg::OFF_DOLLAR]
                     && i_info.off_flags[atc_pkg::OFF_LETTER]
                     && i_info.off_flags[atc_pkg::OFF_CLEAN_END]) begin
            o_result.cls = atc_pkg::CLS_OFFSET;
        end else begin
            o_result.cls = atc_pkg::CLS_UNRECOGNIZED;
        end
        o_result.accepted = (o_result.cls != atc_pkg::CLS_STRING)
                         && (o_result.cls != atc_pkg::CLS_UNRECOGNIZED);
    end

endmodule
